// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/frnl_pkg.sv =====
// Shared constants, codes and types of the fixed-radius neighbor list block.
`timescale 1ns / 1ps

package frnl_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int MAX_LIST    = 16;
    localparam int COORD_WIDTH = 24;

    localparam int ADDR_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int LIST_CNT_W = $clog2(MAX_LIST + 1);

    // field widths of the stream and register interface
    localparam int SLOT_W     = 7;
    localparam int COUNT_W    = 8;
    localparam int RANGE_W    = 23;
    localparam int ID_W       = 8;
    localparam int NCNT_W     = 5;
    localparam int IN_DATA_W  = ((SLOT_W + 3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // distance datapath
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > RANGE_W) ? DIFF_W : RANGE_W;
    localparam int SQ_W   = 2 * RANGE_W;
    localparam int SUM_W  = SQ_W + 2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic REG_SLOT_COUNT = 1'b0;
    localparam logic REG_LINK_RANGE = 1'b1;

    // what travels alongside one memory read through the compare pipeline
    typedef enum logic [1:0] {
        K_NONE,
        K_REF,
        K_ENTRY,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CNT_W-1:0]  idx;
    } t_tag;

    // x in the low bits
    typedef struct packed {
        logic [COORD_WIDTH-1:0] z;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] x;
    } t_pos;

endpackage

// ===== src/frnl_dist.sv =====
// Distance compare pipeline: holds the queried position and tests each entry.
`timescale 1ns / 1ps

module frnl_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  frnl_pkg::t_tag                i_tag,
    input  frnl_pkg::t_pos                i_pos,
    input  logic [frnl_pkg::RANGE_W-1:0]  i_link_range,
    output frnl_pkg::t_tag                o_tag,
    output logic                          o_hit
);
    import frnl_pkg::*;

    t_pos                       r_ref;
    t_tag                       r_tag2;
    t_tag                       r_tag3;
    logic [RANGE_W-1:0]         r_mag [3];
    logic                       r_far2;
    logic                       r_far3;
    logic [SQ_W-1:0]            r_sq [3];
    logic [SQ_W-1:0]            r_range_sq;

    logic [COORD_WIDTH-1:0]     w_cur [3];
    logic [COORD_WIDTH-1:0]     w_ref [3];
    logic signed [DIFF_W-1:0]   w_diff [3];
    logic [DIFF_W-1:0]          w_abs [3];
    logic [RANGE_W-1:0]         w_mag [3];
    logic                       w_far;
    logic [SUM_W-1:0]           w_sum;

    assign w_cur[0] = i_pos.x;
    assign w_cur[1] = i_pos.y;
    assign w_cur[2] = i_pos.z;
    assign w_ref[0] = r_ref.x;
    assign w_ref[1] = r_ref.y;
    assign w_ref[2] = r_ref.z;

    // stage 2: absolute differences; any axis beyond the range rules the entry out
    always_comb begin
        w_far = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = DIFF_W'($signed(w_cur[k])) - DIFF_W'($signed(w_ref[k]));
            w_abs[k]  = w_diff[k][DIFF_W-1] ? DIFF_W'(-w_diff[k]) : DIFF_W'(w_diff[k]);
            w_mag[k]  = RANGE_W'(CMP_W'(w_abs[k]));
            if (CMP_W'(w_abs[k]) > CMP_W'(i_link_range)) begin
                w_far = 1'b1;
            end
        end
    end

    assign w_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    assign o_tag = r_tag3;
    assign o_hit = (r_tag3.kind == K_ENTRY) && !r_far3 && (w_sum <= SUM_W'(r_range_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '{kind: K_NONE, idx: '0};
            r_tag3 <= '{kind: K_NONE, idx: '0};
        end else if (i_adv) begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range_sq <= SQ_W'(i_link_range) * SQ_W'(i_link_range);
        if (i_adv) begin
            if (i_tag.kind == K_REF) begin
                r_ref <= i_pos;
            end
            r_mag  <= w_mag;
            r_far2 <= w_far;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SQ_W'(r_mag[k]) * SQ_W'(r_mag[k]);
            end
            r_far3 <= r_far2;
        end
    end

endmodule

// ===== src/fixed_radius_neighbor_lists.sv =====
// Top level of the fixed-radius neighbor list block.
`timescale 1ns / 1ps

// Keeps a table of 3D positions and lists, for a queried slot, every other slot
// in use whose squared distance is within the squared communication range.
// Input stream: tuser is the mode; a write beat stores the slot's position, a
// query beat starts a scan. Output stream: one beat per neighbor in ascending
// slot order, tlast on the final one, overflow set there when more than
// MAX_LIST neighbors existed; a query with no neighbors, or for a slot at or
// above the slot count, gives one empty beat (id 0, count 0, tlast).
// A query reads the queried entry, then every slot below the slot count, one
// memory read per cycle while the output does not stall, through a four-stage
// compare pipeline; a new beat is taken once the last result of the previous
// query has moved into the output register. The position memory has a single
// read port. When a beat must go out while the receiver stalls, the whole
// scan pipeline holds and resumes where it stopped. Reset clears the control
// registers and the scan state; the position memory is not cleared, so a
// slot must be written before it is queried.
// Slot count and link range are APB registers at byte addresses 0 and 4.
module fixed_radius_neighbor_lists (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [frnl_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // slot, pos_x, pos_y, pos_z, pad
    input  logic                              s_axis_tuser,  // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [frnl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // neighbor_id, list count,
                                                             // overflow, pad
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [frnl_pkg::PADDR_W-1:0]      paddr,
    input  logic [frnl_pkg::PDATA_W-1:0]      pwdata,
    output logic [frnl_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import frnl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state                     r_state, n_state;
    logic [COUNT_W-1:0]         r_slot_count;
    logic [RANGE_W-1:0]         r_link_range;
    logic [CNT_W-1:0]           r_j, n_j;
    logic [CNT_W-1:0]           r_slot, n_slot;
    logic [CNT_W-1:0]           r_used, n_used;
    logic [CNT_W-1:0]           w_used;

    t_pos                       r_mem [MAX_ENTRIES];
    t_pos                       r_rd_data;
    logic [ADDR_W-1:0]          w_rd_addr;
    t_tag                       r_tag1, w_iss;
    t_tag                       w_tag3;
    logic                       w_hit;

    logic                       r_pend_v;
    logic [CNT_W-1:0]           r_pend_idx;
    logic [LIST_CNT_W-1:0]      r_cnt;
    logic                       r_more;
    logic                       w_take;
    logic                       w_list_full;

    logic                       r_m_valid;
    logic [OUT_DATA_W-1:0]      r_m_data, n_m_data;
    logic                       r_m_last, n_m_last;
    logic                       w_push;
    logic                       w_adv;

    logic                       w_s_fire;
    logic                       w_query;
    logic [SLOT_W-1:0]          w_slot;
    t_pos                       w_pos;
    logic                       w_slot_in;
    logic                       w_cfg_wr;

    function automatic logic [OUT_DATA_W-1:0] f_pack(logic [ID_W-1:0] id,
                                                     logic [NCNT_W-1:0] cnt,
                                                     logic ovf);
        f_pack = {{(OUT_DATA_W - ID_W - NCNT_W - 1){1'b0}}, ovf, cnt, id};
    endfunction

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_LINK_RANGE) ? PDATA_W'(r_link_range)
                                                   : PDATA_W'(r_slot_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_link_range <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_SLOT_COUNT) begin
                r_slot_count <= pwdata[COUNT_W-1:0];
            end else begin
                r_link_range <= pwdata[RANGE_W-1:0];
            end
        end
    end

    // ---------------- input side and scan sequencer ----------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;
    assign w_query       = (s_axis_tuser == MODE_QUERY);
    assign w_slot        = s_axis_tdata[SLOT_W-1:0];
    assign w_pos         = t_pos'(s_axis_tdata[SLOT_W +: 3 * COORD_WIDTH]);

    always_comb begin
        if (int'(r_slot_count) > MAX_ENTRIES) begin
            w_used = CNT_W'(MAX_ENTRIES);
        end else begin
            w_used = CNT_W'(r_slot_count);
        end
    end

    assign w_slot_in = int'(w_slot) < int'(w_used);

    always_comb begin
        n_state   = r_state;
        n_j       = r_j;
        n_slot    = r_slot;
        n_used    = r_used;
        w_rd_addr = '0;
        w_iss     = '{kind: K_NONE, idx: '0};
        case (r_state)
            ST_IDLE: begin
                if (w_s_fire && w_query) begin
                    n_used = w_used;
                    if (w_slot_in) begin
                        // first read fetches the queried position itself
                        w_rd_addr  = ADDR_W'(w_slot);
                        w_iss.kind = K_REF;
                        n_slot     = CNT_W'(w_slot);
                        n_j        = '0;
                        n_state    = ST_SCAN;
                    end else begin
                        w_iss.kind = K_END;
                        n_state    = ST_DRAIN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_j == r_used) begin
                    w_iss.kind = K_END;
                    n_state    = ST_DRAIN;
                end else begin
                    w_rd_addr  = r_j[ADDR_W-1:0];
                    w_iss.kind = (r_j == r_slot) ? K_NONE : K_ENTRY;
                    w_iss.idx  = r_j;
                    n_j        = r_j + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (w_tag3.kind == K_END) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
            r_slot  <= '0;
            r_used  <= '0;
            r_tag1  <= '{kind: K_NONE, idx: '0};
        end else if (w_adv) begin
            r_state <= n_state;
            r_j     <= n_j;
            r_slot  <= n_slot;
            r_used  <= n_used;
            r_tag1  <= w_iss;
        end
    end

    // ---------------- position memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_s_fire && (s_axis_tuser == MODE_WRITE) && (int'(w_slot) < MAX_ENTRIES)) begin
            r_mem[ADDR_W'(w_slot)] <= w_pos;
        end
        if (w_adv) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    frnl_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_tag        (r_tag1),
        .i_pos        (r_rd_data),
        .i_link_range (r_link_range),
        .o_tag        (w_tag3),
        .o_hit        (w_hit)
    );

    // ---------------- result list ----------------
    // One hit is held back until the next hit or the end of the scan decides
    // whether it is the final beat.
    assign w_list_full = (int'(r_cnt) >= MAX_LIST);
    assign w_take      = (w_tag3.kind == K_ENTRY) && w_hit && !w_list_full;

    always_comb begin
        w_push   = 1'b0;
        n_m_data = f_pack(ID_W'(r_pend_idx) + ID_W'(1), NCNT_W'(r_cnt), 1'b0);
        n_m_last = 1'b0;
        if (w_tag3.kind == K_END) begin
            w_push   = 1'b1;
            n_m_last = 1'b1;
            if (r_pend_v) begin
                n_m_data = f_pack(ID_W'(r_pend_idx) + ID_W'(1), NCNT_W'(r_cnt), r_more);
            end else begin
                n_m_data = f_pack('0, '0, 1'b0);
            end
        end else if (w_take && r_pend_v) begin
            w_push = 1'b1;
        end
    end

    // everything moves unless a beat must go out and the output register is held
    assign w_adv = !w_push || !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_cnt     <= '0;
            r_more    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_adv && w_push) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_adv) begin
                if (w_tag3.kind == K_END) begin
                    r_pend_v <= 1'b0;
                    r_cnt    <= '0;
                    r_more   <= 1'b0;
                end else if (w_take) begin
                    r_pend_v <= 1'b1;
                    r_cnt    <= r_cnt + LIST_CNT_W'(1);
                end else if ((w_tag3.kind == K_ENTRY) && w_hit) begin
                    r_more <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_push) begin
            r_m_data <= n_m_data;
            r_m_last <= n_m_last;
        end
        if (w_adv && w_take) begin
            r_pend_idx <= w_tag3.idx;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// ===== src/frnl_checker.sv =====
// Port-level checks of the neighbor list block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frnl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [frnl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              m_axis_tlast
);
    import frnl_pkg::*;

    // a held output beat keeps its payload
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")

    // an empty result is always the final beat of its query, with zero count and no overflow
    `CHK_NOW(a_empty_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0), m_axis_tlast && (m_axis_tdata[13:8] == 6'd0), "empty result not final or with count")

    // overflow only on the final beat of a full list
    `CHK_NOW(a_ovf_full, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[13], m_axis_tlast && (m_axis_tdata[12:8] == 5'(MAX_LIST)), "overflow outside a full final beat")

    // no new beat is taken right after a query is accepted
    `CHK_NEXT(a_query_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY), !s_axis_tready, "input ready during a query scan")

endmodule

bind fixed_radius_neighbor_lists frnl_checker u_frnl_checker (.*);
